### design/llrb_pkg.sv
// Package for the last-lines ring buffer.
// Holds sizes, derived widths, action codes, the sequencer states and the line-count helper.
// Has no dependencies.
package llrb_pkg;

    // Ring geometry
    localparam int MAX_LINES  = 128;
    localparam int LINE_BYTES = 128;

    // Derived widths
    localparam int SLOT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // Line count used when the register holds no usable value
    localparam int DEFAULT_N = (10 > MAX_LINES) ? MAX_LINES : 10;
    localparam logic [7:0] TAIL_RESET = 8'd10;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_EOL    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // Read sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_RESULT
    } t_state;

    // Number of lines kept: out-of-range register values fall back to the default
    function automatic t_cnt eff_n(input logic [7:0] tail);
        t_cnt n;
        if (tail == 8'd0 || 32'(tail) > MAX_LINES) begin
            n = t_cnt'(DEFAULT_N);
        end else begin
            n = t_cnt'(tail);
        end
        return n;
    endfunction

endpackage

### design/last_lines_ring_buffer.sv
// Top level of the last-lines ring buffer: line store memory, pointers and read sequencer.
// Depends on llrb_pkg.

// Keeps the newest N lines (N from the tail_lines register, 1..128, other values mean 10)
// in a ring of fixed 128-byte slots held in one synchronous store. Append, end-of-line and
// clear transactions produce no result. A read runs through accept (the first read of a
// replay also commits an open partial line), a registered store fetch and the result step,
// which waits while the output register is still full; after the replay ends, a read goes
// from accept straight to the result. The store needs no initialization after reset.
module last_lines_ring_buffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: tail_lines
    input  logic       i_cfg_wen,
    input  logic [7:0] i_cfg_wdata,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] action
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // line_end
    output logic [1:0] m_axis_tuser    // [0] final_line, [1] empty_res
);

    // Control registers
    llrb_pkg::t_state r_state, n_state;
    logic [7:0]       r_tail, n_tail;
    llrb_pkg::t_slot  r_oldest, n_oldest;
    llrb_pkg::t_cnt   r_held, n_held;
    llrb_pkg::t_slot  r_wslot, n_wslot;
    llrb_pkg::t_pos   r_wpos, n_wpos;
    logic             r_open, n_open;
    llrb_pkg::t_cnt   r_rline, n_rline;
    llrb_pkg::t_pos   r_rpos, n_rpos;
    logic             r_replay, n_replay;

    // Pending result info between fetch and result
    logic r_pend_empty, n_pend_empty;
    logic r_pend_fin, n_pend_fin;
    logic r_pend_last, n_pend_last;

    // Output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_end, n_out_end;
    logic       r_out_fin, n_out_fin;
    logic       r_out_empty, n_out_empty;

    // Line store
    logic [7:0]      r_line_store [llrb_pkg::DEPTH];
    logic [7:0]      r_mem_q;
    logic            mem_we;
    llrb_pkg::t_addr mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    llrb_pkg::t_addr mem_raddr;

    llrb_pkg::t_action act;
    logic              in_acc;
    llrb_pkg::t_cnt    n_lines;
    llrb_pkg::t_cnt    total;
    llrb_pkg::t_slot   open_slot;
    llrb_pkg::t_slot   cur_slot;
    llrb_pkg::t_pos    cur_pos;
    logic [llrb_pkg::CNT_W:0] slot_sum;
    logic [llrb_pkg::CNT_W:0] old_inc;
    llrb_pkg::t_slot   rd_slot;

    assign act           = llrb_pkg::t_action'(s_axis_tuser);
    assign s_axis_tready = (r_state == llrb_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign n_lines   = llrb_pkg::eff_n(r_tail);
    assign total     = (r_held < n_lines) ? r_held : n_lines;
    assign open_slot = (r_held < n_lines) ? llrb_pkg::t_slot'(r_held) : r_oldest;
    // slot and position the next write goes to (a closed line opens here)
    assign cur_slot  = r_open ? r_wslot : open_slot;
    assign cur_pos   = r_open ? r_wpos : '0;
    assign old_inc   = (llrb_pkg::CNT_W + 1)'(r_oldest) + 1'b1;

    // replay slot: oldest plus line index, wrapped at N with one subtract
    assign slot_sum  = (llrb_pkg::CNT_W + 1)'(r_oldest) + (llrb_pkg::CNT_W + 1)'(r_rline);
    always_comb begin
        if (slot_sum >= (llrb_pkg::CNT_W + 1)'(n_lines)) begin
            rd_slot = llrb_pkg::t_slot'(slot_sum - (llrb_pkg::CNT_W + 1)'(n_lines));
        end else begin
            rd_slot = llrb_pkg::t_slot'(slot_sum);
        end
    end

    // Next state, pointer updates and store control
    always_comb begin
        n_state      = r_state;
        n_tail       = r_tail;
        n_oldest     = r_oldest;
        n_held       = r_held;
        n_wslot      = r_wslot;
        n_wpos       = r_wpos;
        n_open       = r_open;
        n_rline      = r_rline;
        n_rpos       = r_rpos;
        n_replay     = r_replay;
        n_pend_empty = r_pend_empty;
        n_pend_fin   = r_pend_fin;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_end    = r_out_end;
        n_out_fin    = r_out_fin;
        n_out_empty  = r_out_empty;
        mem_we       = 1'b0;
        mem_waddr    = {cur_slot, cur_pos};
        mem_wdata    = 8'd0;
        mem_re       = 1'b0;
        mem_raddr    = {rd_slot, r_rpos};

        if (i_cfg_wen) begin
            n_tail = i_cfg_wdata;
        end

        unique case (r_state)
            llrb_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (act != llrb_pkg::ACT_READ) begin
                        n_replay = 1'b0;
                        n_rline  = '0;
                        n_rpos   = '0;
                    end
                    unique case (act)
                        llrb_pkg::ACT_APPEND: begin
                            n_open  = 1'b1;
                            n_wslot = cur_slot;
                            n_wpos  = cur_pos;
                            if (cur_pos < llrb_pkg::t_pos'(llrb_pkg::LINE_BYTES - 1)) begin
                                mem_we    = 1'b1;
                                mem_wdata = s_axis_tdata;
                                // a zero byte closes the content of the line
                                n_wpos = (s_axis_tdata == 8'd0) ?
                                    llrb_pkg::t_pos'(llrb_pkg::LINE_BYTES - 1) :
                                    cur_pos + 1'b1;
                            end
                        end
                        llrb_pkg::ACT_EOL: begin
                            // commit: terminator, then grow or rotate the ring
                            mem_we  = 1'b1;
                            n_wslot = cur_slot;
                            n_open  = 1'b0;
                            n_wpos  = '0;
                            if (r_held < n_lines) begin
                                n_held = r_held + 1'b1;
                            end else begin
                                n_oldest = (old_inc < (llrb_pkg::CNT_W + 1)'(n_lines)) ?
                                    llrb_pkg::t_slot'(old_inc) : '0;
                            end
                        end
                        llrb_pkg::ACT_CLEAR: begin
                            n_oldest = '0;
                            n_held   = '0;
                            n_wslot  = '0;
                            n_wpos   = '0;
                            n_open   = 1'b0;
                        end
                        llrb_pkg::ACT_READ: begin
                            if (!r_replay && r_rline != '0) begin
                                // replay already finished
                                n_pend_empty = 1'b1;
                                n_state      = llrb_pkg::S_RESULT;
                            end else begin
                                if (!r_replay && r_open) begin
                                    // first read commits the open partial line
                                    mem_we = 1'b1;
                                    n_open = 1'b0;
                                    n_wpos = '0;
                                    if (r_held < n_lines) begin
                                        n_held = r_held + 1'b1;
                                    end else begin
                                        n_oldest = (old_inc < (llrb_pkg::CNT_W + 1)'(n_lines)) ?
                                            llrb_pkg::t_slot'(old_inc) : '0;
                                    end
                                end
                                if (!r_replay) begin
                                    n_rline = '0;
                                    n_rpos  = '0;
                                end
                                n_replay = 1'b1;
                                n_state  = llrb_pkg::S_FETCH;
                            end
                        end
                    endcase
                end
            end
            llrb_pkg::S_FETCH: begin
                n_state = llrb_pkg::S_RESULT;
                if (r_rline >= total) begin
                    n_replay     = 1'b0;
                    n_pend_empty = 1'b1;
                end else begin
                    mem_re       = 1'b1;
                    n_pend_empty = 1'b0;
                    n_pend_fin   = ((llrb_pkg::CNT_W + 1)'(r_rline) + 1'b1) ==
                                   (llrb_pkg::CNT_W + 1)'(total);
                    n_pend_last  = (r_rpos == llrb_pkg::t_pos'(llrb_pkg::LINE_BYTES - 1));
                end
            end
            llrb_pkg::S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_state      = llrb_pkg::S_IDLE;
                    n_pend_empty = 1'b0;
                    n_out_byte   = 8'd0;
                    n_out_end    = 1'b0;
                    n_out_fin    = 1'b0;
                    n_out_empty  = 1'b0;
                    if (r_pend_empty) begin
                        n_out_empty = 1'b1;
                    end else if (r_mem_q == 8'd0 || r_pend_last) begin
                        n_out_end = 1'b1;
                        n_out_fin = r_pend_fin;
                        n_rline   = r_rline + 1'b1;
                        n_rpos    = '0;
                        if (r_pend_fin) begin
                            n_replay = 1'b0;
                        end
                    end else begin
                        n_out_byte = r_mem_q;
                        n_rpos     = r_rpos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = llrb_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= llrb_pkg::S_IDLE;
            r_tail       <= llrb_pkg::TAIL_RESET;
            r_oldest     <= '0;
            r_held       <= '0;
            r_wslot      <= '0;
            r_wpos       <= '0;
            r_open       <= 1'b0;
            r_rline      <= '0;
            r_rpos       <= '0;
            r_replay     <= 1'b0;
            r_pend_empty <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tail       <= n_tail;
            r_oldest     <= n_oldest;
            r_held       <= n_held;
            r_wslot      <= n_wslot;
            r_wpos       <= n_wpos;
            r_open       <= n_open;
            r_rline      <= n_rline;
            r_rpos       <= n_rpos;
            r_replay     <= n_replay;
            r_pend_empty <= n_pend_empty;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_fin  <= n_pend_fin;
        r_pend_last <= n_pend_last;
        r_out_byte  <= n_out_byte;
        r_out_end   <= n_out_end;
        r_out_fin   <= n_out_fin;
        r_out_empty <= n_out_empty;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_line_store[mem_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_end;
    assign m_axis_tuser  = {r_out_empty, r_out_fin};

    // Checks
    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && act == llrb_pkg::ACT_READ) |=> !s_axis_tready)
        else $error("input accepted right after a read transaction");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != llrb_pkg::S_IDLE) |-> !mem_we)
        else $error("store written while a read is in flight");

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == llrb_pkg::S_RESULT))
        else $error("result loaded outside the result step");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= llrb_pkg::MAX_LINES)
        else $error("line count beyond ring size");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_empty && r_out_end) && !(r_out_fin && !r_out_end))
        else $error("inconsistent result flags");

endmodule
